[sv/stt_pkg.sv]
package stt_pkg;

  localparam int unsigned OffsetBits   = 24;
  localparam int unsigned PositionBits = 16;
  localparam int unsigned KeywordChars = 8;

  localparam logic [OffsetBits-1:0]   OffMax = {OffsetBits{1'b1}};
  localparam logic [PositionBits-1:0] PosMax = {PositionBits{1'b1}};
  localparam logic [15:0]             LenMax = 16'hFFFF;

  // mode codes
  localparam logic [3:0] MIdle     = 4'd0;
  localparam logic [3:0] MIdent    = 4'd1;
  localparam logic [3:0] MNumber   = 4'd2;
  localparam logic [3:0] MFraction = 4'd3;
  localparam logic [3:0] MString   = 4'd4;
  localparam logic [3:0] MEscape   = 4'd5;
  localparam logic [3:0] MComment  = 4'd6;
  localparam logic [3:0] MEnded    = 4'd7;

  // held operator codes
  localparam logic [2:0] PNone  = 3'd0;
  localparam logic [2:0] PSlash = 3'd1;
  localparam logic [2:0] PEq    = 3'd2;
  localparam logic [2:0] PBang  = 3'd3;
  localparam logic [2:0] PLt    = 3'd4;
  localparam logic [2:0] PGt    = 3'd5;
  localparam logic [2:0] PDot   = 3'd6;

  // result kinds
  localparam logic [5:0] KEnd     = 6'd0;
  localparam logic [5:0] KIdent   = 6'd1;
  localparam logic [5:0] KNumber  = 6'd2;
  localparam logic [5:0] KString  = 6'd3;
  localparam logic [5:0] KKw0     = 6'd4;
  localparam logic [5:0] KLParen  = 6'd24;
  localparam logic [5:0] KRParen  = 6'd25;
  localparam logic [5:0] KLBrace  = 6'd26;
  localparam logic [5:0] KRBrace  = 6'd27;
  localparam logic [5:0] KSemi    = 6'd28;
  localparam logic [5:0] KComma   = 6'd29;
  localparam logic [5:0] KDot     = 6'd30;
  localparam logic [5:0] KAssign  = 6'd31;
  localparam logic [5:0] KBang    = 6'd33;
  localparam logic [5:0] KLt      = 6'd35;
  localparam logic [5:0] KGt      = 6'd37;
  localparam logic [5:0] KPlus    = 6'd39;
  localparam logic [5:0] KMinus   = 6'd40;
  localparam logic [5:0] KStar    = 6'd41;
  localparam logic [5:0] KSlash   = 6'd42;
  localparam logic [5:0] KStrByte = 6'd44;
  localparam logic [5:0] KBadChar = 6'd45;
  localparam logic [5:0] KUnterm  = 6'd46;

  localparam int unsigned NumKw = 20;

  typedef logic [KeywordChars*8-1:0] word_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic [15:0] token_col;
    logic [7:0]  string_byte;
  } token_t;

  // keyword text, first character in the low byte
  function automatic word_t kw_text(input logic [4:0] k);
    word_t w;
    w = '0;
    case (k)
      5'd0:  w[23:0] = {"t", "e", "l"};
      5'd1:  w[39:0] = {"t", "n", "i", "r", "p"};
      5'd2:  w[15:0] = {"f", "i"};
      5'd3:  w[31:0] = {"e", "s", "l", "e"};
      5'd4:  w[39:0] = {"e", "l", "i", "h", "w"};
      5'd5:  w[31:0] = {"e", "u", "r", "t"};
      5'd6:  w[39:0] = {"e", "s", "l", "a", "f"};
      5'd7:  w[23:0] = {"l", "i", "n"};
      5'd8:  w[23:0] = {"d", "n", "a"};
      5'd9:  w[15:0] = {"r", "o"};
      5'd10: w[15:0] = {"i", "u"};
      5'd11: w[31:0] = {"t", "i", "n", "i"};
      5'd12: w[31:0] = {"t", "x", "e", "t"};
      5'd13: w[47:0] = {"n", "o", "t", "t", "u", "b"};
      5'd14: w[39:0] = {"t", "u", "p", "n", "i"};
      5'd15: w[23:0] = {"n", "u", "r"};
      5'd16: w[39:0] = {"r", "a", "e", "l", "c"};
      5'd17: w[39:0] = {"e", "l", "t", "i", "t"};
      5'd18: w[47:0] = {"t", "c", "e", "l", "e", "s"};
      5'd19: w[63:0] = {"x", "o", "b", "k", "c", "e", "h", "c"};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    logic [3:0] l;
    case (k)
      5'd0, 5'd7, 5'd8, 5'd15:                 l = 4'd3;
      5'd1, 5'd4, 5'd6, 5'd14, 5'd16, 5'd17:   l = 4'd5;
      5'd2, 5'd9, 5'd10:                       l = 4'd2;
      5'd3, 5'd5, 5'd11, 5'd12:                l = 4'd4;
      5'd13, 5'd18:                            l = 4'd6;
      5'd19:                                   l = 4'd8;
      default:                                 l = 4'd0;
    endcase
    return l;
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

endpackage

[sv/stt_if.sv]
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  kind;
  logic [23:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] token_line;
  logic [15:0] token_col;
  logic [7:0]  string_byte;
  logic        last;
  modport source (output valid, kind, start_offset, token_length, token_line, token_col,
                  string_byte, last, input ready);
  modport sink (input valid, kind, start_offset, token_length, token_line, token_col,
                string_byte, last, output ready);
endinterface

[sv/stt_kw_match.sv]
module stt_kw_match (
  input  stt_pkg::word_t word_i,
  input  logic [15:0]    len_i,
  output logic [5:0]     kind_o
);

  always_comb begin
    kind_o = stt_pkg::KIdent;
    for (int k = stt_pkg::NumKw - 1; k >= 0; k--) begin
      if (len_i == {12'd0, stt_pkg::kw_len(5'(k))} && word_i == stt_pkg::kw_text(5'(k))) begin
        kind_o = stt_pkg::KKw0 + 6'(k);
      end
    end
  end

endmodule

[sv/stt_core.sv]
// one item per cycle while step_i is high: state update plus up to three results for the result queue
module stt_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          text_byte_i,
  input  logic                end_of_text_i,
  output stt_pkg::token_t     res_o [3],
  output logic [1:0]          res_n_o
);

  logic [3:0]  mode_q, mode_d;
  logic [2:0]  pend_q, pend_d;
  stt_pkg::word_t word_q, word_d;
  logic [15:0] len_q, len_d;
  logic [23:0] rs_off_q, rs_off_d;
  logic [15:0] rs_line_q, rs_line_d, rs_col_q, rs_col_d;
  logic [23:0] off_q, off_d;
  logic [15:0] line_q, line_d, col_q, col_d;
  logic        halt_q, halt_d;
  logic [23:0] op_off_q, op_off_d;
  logic [15:0] op_line_q, op_line_d, op_col_q, op_col_d;

  logic [7:0]  c;
  logic        eot, fall;
  logic [5:0]  kw_kind, k1;
  logic [15:0] len_inc;

  stt_kw_match u_kw (.word_i(word_q), .len_i(len_q), .kind_o(kw_kind));

  assign len_inc = (len_q < stt_pkg::LenMax) ? len_q + 16'd1 : len_q;

  function automatic stt_pkg::token_t tok(input logic [5:0] k, input logic [23:0] o,
                                          input logic [15:0] l, input logic [15:0] ln,
                                          input logic [15:0] cl, input logic [7:0] sb);
    stt_pkg::token_t t;
    t.kind = k; t.start_offset = o; t.token_length = l;
    t.token_line = ln; t.token_col = cl; t.string_byte = sb;
    return t;
  endfunction

  always_comb begin
    mode_d = mode_q; pend_d = pend_q; word_d = word_q; len_d = len_q;
    rs_off_d = rs_off_q; rs_line_d = rs_line_q; rs_col_d = rs_col_q;
    off_d = off_q; line_d = line_q; col_d = col_q; halt_d = halt_q;
    op_off_d = op_off_q; op_line_d = op_line_q; op_col_d = op_col_q;
    res_o[0] = '0; res_o[1] = '0; res_o[2] = '0;
    res_n_o = 2'd0;
    fall = 1'b0;
    k1 = stt_pkg::KEnd;
    eot = end_of_text_i || (text_byte_i == 8'd0);
    c = eot ? 8'd0 : text_byte_i;

    if (halt_q) begin
      // nothing
    end else if (mode_q == stt_pkg::MEnded) begin
      res_o[0] = tok(stt_pkg::KEnd, off_q, 16'd0, line_q, col_q, 8'd0);
      res_n_o = 2'd1;
    end else begin
      case (mode_q)
        stt_pkg::MString: begin
          if (eot) begin
            res_o[0] = tok(stt_pkg::KUnterm, rs_off_q, 16'd0, rs_line_q, rs_col_q, 8'd0);
            res_n_o = 2'd1; halt_d = 1'b1;
          end else if (c == "\"") begin
            len_d = len_inc;
            res_o[0] = tok(stt_pkg::KString, rs_off_q, len_inc, rs_line_q, rs_col_q, 8'd0);
            res_n_o = 2'd1; mode_d = stt_pkg::MIdle;
          end else if (c == "\\") begin
            len_d = len_inc; mode_d = stt_pkg::MEscape;
          end else begin
            len_d = len_inc;
            res_o[0] = tok(stt_pkg::KStrByte, rs_off_q, 16'd0, rs_line_q, rs_col_q, c);
            res_n_o = 2'd1;
          end
        end
        stt_pkg::MEscape: begin
          if (eot) begin
            res_o[0] = tok(stt_pkg::KUnterm, rs_off_q, 16'd0, rs_line_q, rs_col_q, 8'd0);
            res_n_o = 2'd1; halt_d = 1'b1;
          end else begin
            len_d = len_inc; mode_d = stt_pkg::MString;
            res_o[0] = tok(stt_pkg::KStrByte, rs_off_q, 16'd0, rs_line_q, rs_col_q,
                           (c == "n") ? 8'h0A : (c == "t") ? 8'h09 : (c == "r") ? 8'h0D : c);
            res_n_o = 2'd1;
          end
        end
        stt_pkg::MComment: begin
          if (eot || c == 8'h0A) begin
            mode_d = stt_pkg::MIdle; fall = 1'b1;
          end
        end
        stt_pkg::MIdent: begin
          if (!eot && (stt_pkg::alpha_char(c) || stt_pkg::digit_char(c))) begin
            for (int i = 0; i < stt_pkg::KeywordChars; i++) begin
              if (len_q == 16'(i)) word_d[i*8 +: 8] = c;
            end
            len_d = len_inc;
          end else begin
            res_o[0] = tok(kw_kind, rs_off_q, len_q, rs_line_q, rs_col_q, 8'd0);
            res_n_o = 2'd1; mode_d = stt_pkg::MIdle; fall = 1'b1;
          end
        end
        stt_pkg::MNumber: begin
          if (pend_q == stt_pkg::PDot) begin
            pend_d = stt_pkg::PNone;
            if (!eot && stt_pkg::digit_char(c)) begin
              len_d = (len_q < 16'hFFFE) ? len_q + 16'd2 : stt_pkg::LenMax;
              mode_d = stt_pkg::MFraction;
            end else begin
              res_o[0] = tok(stt_pkg::KNumber, rs_off_q, len_q, rs_line_q, rs_col_q, 8'd0);
              res_o[1] = tok(stt_pkg::KDot, op_off_q, 16'd1, op_line_q, op_col_q, 8'd0);
              res_n_o = 2'd2; mode_d = stt_pkg::MIdle; fall = 1'b1;
            end
          end else if (!eot && stt_pkg::digit_char(c)) begin
            len_d = len_inc;
          end else if (!eot && c == ".") begin
            pend_d = stt_pkg::PDot;
            op_off_d = off_q; op_line_d = line_q; op_col_d = col_q;
          end else begin
            res_o[0] = tok(stt_pkg::KNumber, rs_off_q, len_q, rs_line_q, rs_col_q, 8'd0);
            res_n_o = 2'd1; mode_d = stt_pkg::MIdle; fall = 1'b1;
          end
        end
        stt_pkg::MFraction: begin
          if (!eot && stt_pkg::digit_char(c)) begin
            len_d = len_inc;
          end else begin
            res_o[0] = tok(stt_pkg::KNumber, rs_off_q, len_q, rs_line_q, rs_col_q, 8'd0);
            res_n_o = 2'd1; mode_d = stt_pkg::MIdle; fall = 1'b1;
          end
        end
        default: begin
          mode_d = stt_pkg::MIdle;
          pend_d = stt_pkg::PNone;
          if (pend_q == stt_pkg::PSlash) begin
            if (!eot && c == "/") begin
              mode_d = stt_pkg::MComment;
            end else begin
              res_o[0] = tok(stt_pkg::KSlash, op_off_q, 16'd1, op_line_q, op_col_q, 8'd0);
              res_n_o = 2'd1; fall = 1'b1;
            end
          end else if (pend_q >= stt_pkg::PEq && pend_q <= stt_pkg::PGt) begin
            case (pend_q)
              stt_pkg::PEq:   k1 = stt_pkg::KAssign;
              stt_pkg::PBang: k1 = stt_pkg::KBang;
              stt_pkg::PLt:   k1 = stt_pkg::KLt;
              default:        k1 = stt_pkg::KGt;
            endcase
            if (!eot && c == "=") begin
              res_o[0] = tok(k1 + 6'd1, op_off_q, 16'd2, op_line_q, op_col_q, 8'd0);
              res_n_o = 2'd1;
            end else begin
              res_o[0] = tok(k1, op_off_q, 16'd1, op_line_q, op_col_q, 8'd0);
              res_n_o = 2'd1; fall = 1'b1;
            end
          end else begin
            fall = 1'b1;
          end
        end
      endcase

      // byte handling with nothing open
      if (fall) begin
        if (eot) begin
          res_o[res_n_o] = tok(stt_pkg::KEnd, off_q, 16'd0, line_q, col_q, 8'd0);
          res_n_o = res_n_o + 2'd1; mode_d = stt_pkg::MEnded;
        end else if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
          // blank
        end else if (stt_pkg::alpha_char(c) || stt_pkg::digit_char(c) || c == "\"") begin
          mode_d = stt_pkg::alpha_char(c) ? stt_pkg::MIdent :
                   stt_pkg::digit_char(c) ? stt_pkg::MNumber : stt_pkg::MString;
          len_d = 16'd1; rs_off_d = off_q; rs_line_d = line_q; rs_col_d = col_q;
          word_d = {{(stt_pkg::KeywordChars*8-8){1'b0}}, c};
        end else if (c == "/" || c == "=" || c == "!" || c == "<" || c == ">") begin
          pend_d = (c == "/") ? stt_pkg::PSlash : (c == "=") ? stt_pkg::PEq :
                   (c == "!") ? stt_pkg::PBang : (c == "<") ? stt_pkg::PLt : stt_pkg::PGt;
          op_off_d = off_q; op_line_d = line_q; op_col_d = col_q;
        end else begin
          case (c)
            "(":     k1 = stt_pkg::KLParen;
            ")":     k1 = stt_pkg::KRParen;
            "{":     k1 = stt_pkg::KLBrace;
            "}":     k1 = stt_pkg::KRBrace;
            ";":     k1 = stt_pkg::KSemi;
            ",":     k1 = stt_pkg::KComma;
            ".":     k1 = stt_pkg::KDot;
            "+":     k1 = stt_pkg::KPlus;
            "-":     k1 = stt_pkg::KMinus;
            "*":     k1 = stt_pkg::KStar;
            default: k1 = stt_pkg::KBadChar;
          endcase
          if (k1 == stt_pkg::KBadChar) begin
            res_o[res_n_o] = tok(k1, off_q, 16'd0, line_q, col_q, 8'd0);
            halt_d = 1'b1;
          end else begin
            res_o[res_n_o] = tok(k1, off_q, 16'd1, line_q, col_q, 8'd0);
          end
          res_n_o = res_n_o + 2'd1;
        end
      end

      if (!eot && !halt_d) begin
        if (off_q < stt_pkg::OffMax) off_d = off_q + 24'd1;
        if (c == 8'h0A) begin
          if (line_q < stt_pkg::PosMax) line_d = line_q + 16'd1;
          col_d = 16'd1;
        end else if (col_q < stt_pkg::PosMax) begin
          col_d = col_q + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= stt_pkg::MIdle; pend_q <= stt_pkg::PNone; word_q <= '0; len_q <= '0;
      rs_off_q <= '0; rs_line_q <= 16'd1; rs_col_q <= 16'd1;
      off_q <= '0; line_q <= 16'd1; col_q <= 16'd1; halt_q <= 1'b0;
      op_off_q <= '0; op_line_q <= 16'd1; op_col_q <= 16'd1;
    end else if (step_i) begin
      mode_q <= mode_d; pend_q <= pend_d; word_q <= word_d; len_q <= len_d;
      rs_off_q <= rs_off_d; rs_line_q <= rs_line_d; rs_col_q <= rs_col_d;
      off_q <= off_d; line_q <= line_d; col_q <= col_d; halt_q <= halt_d;
      op_off_q <= op_off_d; op_line_q <= op_line_d; op_col_q <= op_col_d;
    end
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt flag cleared");
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> res_n_o == 2'd0) else $error("results while halted");
  a_line_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != 16'd0 && col_q != 16'd0) else $error("position reached zero");

endmodule

[sv/source_text_tokenizer_top.sv]
// channel | dir | payload
// in_i    | in  | text_byte, end_of_text
// out_o   | out | kind, start_offset, token_length, token_line, token_col, string_byte, last
// one item per cycle while in_i.ready is high: the byte is decoded in the cycle it is taken
// and its 0..3 results go into a 4-deep result queue; results leave one per cycle while
// out_o.ready is high, from the cycle after input is taken; input is ready while the queue
// holds at most one result, or two with one leaving; with the output always ready, a
// three-result item holds input off while the queue holds three results; items that give
// two or more results in a row slow down to one result per cycle; rst_ni clears state and the queue asynchronously
module source_text_tokenizer_top (
  input logic         clk_i,
  input logic         rst_ni,
  stt_in_if.sink      in_i,
  stt_out_if.source   out_o
);

  typedef struct packed {
    stt_pkg::token_t tok;
    logic            last;
  } entry_t;

  stt_pkg::token_t res [3];
  logic [1:0] res_n;
  logic       step;
  entry_t     fifo_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign in_i.ready = (cnt_q <= 3'd1) || (cnt_q == 3'd2 && pop);
  assign step = in_i.valid && in_i.ready;
  assign pop = out_o.valid && out_o.ready;

  stt_core u_core (
    .clk_i, .rst_ni, .step_i(step),
    .text_byte_i(in_i.text_byte), .end_of_text_i(in_i.end_of_text),
    .res_o(res), .res_n_o(res_n)
  );

  always_ff @(posedge clk_i) begin
    if (step) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < res_n) begin
          fifo_q[wr_q + 2'(i)] <= '{tok: res[i], last: (2'(i + 1) == res_n)};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      if (step) wr_q <= wr_q + res_n;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + (step ? {1'b0, res_n} : 3'd0) - {2'b0, pop};
    end
  end

  assign out_o.valid        = cnt_q != 3'd0;
  assign out_o.kind         = fifo_q[rd_q].tok.kind;
  assign out_o.start_offset = fifo_q[rd_q].tok.start_offset;
  assign out_o.token_length = fifo_q[rd_q].tok.token_length;
  assign out_o.token_line   = fifo_q[rd_q].tok.token_line;
  assign out_o.token_col    = fifo_q[rd_q].tok.token_col;
  assign out_o.string_byte  = fifo_q[rd_q].tok.string_byte;
  assign out_o.last         = fifo_q[rd_q].last;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("result queue overflow");
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> (cnt_q - {2'b0, pop} + {1'b0, res_n}) <= 3'd4) else $error("no room for results");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 3'd4) |-> (wr_q - rd_q) == cnt_q[1:0]) else $error("queue pointers disagree");

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    stt_pkg::token_t tok;
    logic            last;
  } lexed_t;

  logic clk_i;
  logic rst_ni;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  source_text_tokenizer_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // lexer state as predicted
  logic [3:0]  lx_mode;
  logic [2:0]  lx_held;
  logic [7:0]  lx_prefix [stt_pkg::KeywordChars];
  logic [15:0] lx_run_len;
  logic [23:0] lx_run_off;
  logic [15:0] lx_run_line;
  logic [15:0] lx_run_col;
  logic [23:0] lx_off;
  logic [15:0] lx_line;
  logic [15:0] lx_col;
  logic        lx_halted;
  logic [23:0] lx_op_off;
  logic [15:0] lx_op_line;
  logic [15:0] lx_op_col;

  lexed_t      item_tokens [$];
  lexed_t      expected_tokens [$];
  logic [7:0]  text_q [$];

  string       keywords [20] = '{"let", "print", "if", "else", "while", "true", "false",
                                 "nil", "and", "or", "ui", "init", "text", "button",
                                 "input", "run", "clear", "title", "select", "checkbox"};
  string       operators [19] = '{"(", ")", "{", "}", ";", ",", ".", "=", "==", "!", "!=",
                                  "<", "<=", ">", ">=", "+", "-", "*", "/"};

  bit          failed = 1'b0;
  bit          idle_on;
  int unsigned cycle_cnt = 0;
  int unsigned items_sent;
  int unsigned stall_left;

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function void lexer_clear();
    lx_mode = stt_pkg::MIdle;
    lx_held = stt_pkg::PNone;
    foreach (lx_prefix[i]) lx_prefix[i] = '0;
    lx_run_len = '0;
    lx_run_off = '0;
    lx_run_line = 16'd1;
    lx_run_col = 16'd1;
    lx_off = '0;
    lx_line = 16'd1;
    lx_col = 16'd1;
    lx_halted = 1'b0;
    lx_op_off = '0;
    lx_op_line = 16'd1;
    lx_op_col = 16'd1;
  endfunction

  function void put(logic [5:0] kind, logic [23:0] off, logic [15:0] len, logic [15:0] ln,
                    logic [15:0] col, logic [7:0] sb);
    lexed_t r;
    r.tok.kind = kind;
    r.tok.start_offset = off;
    r.tok.token_length = len;
    r.tok.token_line = ln;
    r.tok.token_col = col;
    r.tok.string_byte = sb;
    r.last = 1'b0;
    if (item_tokens.size() < 3) item_tokens.push_back(r);
  endfunction

  function void put_run(logic [5:0] kind, logic [15:0] len, logic [7:0] sb);
    put(kind, lx_run_off, len, lx_run_line, lx_run_col, sb);
  endfunction

  function void grow_run();
    if (lx_run_len != stt_pkg::LenMax) lx_run_len++;
  endfunction

  function void open_run(logic [3:0] m);
    lx_mode = m;
    lx_run_len = 16'd1;
    lx_run_off = lx_off;
    lx_run_line = lx_line;
    lx_run_col = lx_col;
  endfunction

  function void hold_op(logic [2:0] p);
    lx_held = p;
    lx_op_off = lx_off;
    lx_op_line = lx_line;
    lx_op_col = lx_col;
  endfunction

  function void put_word();
    logic [5:0] kind;
    bit same;
    kind = stt_pkg::KIdent;
    for (int k = 0; k < 20; k++) begin
      same = lx_run_len == keywords[k].len() && keywords[k].len() <= stt_pkg::KeywordChars;
      for (int i = 0; i < keywords[k].len() && same; i++)
        if (lx_prefix[i] != keywords[k][i]) same = 0;
      if (same) begin
        kind = stt_pkg::KKw0 + 6'(k);
        break;
      end
    end
    put_run(kind, lx_run_len, 8'd0);
  endfunction

  function void lex_idle(logic [7:0] c, logic e);
    logic [5:0] k;
    if (e) begin
      put(stt_pkg::KEnd, lx_off, 16'd0, lx_line, lx_col, 8'd0);
      lx_mode = stt_pkg::MEnded;
      return;
    end
    if (c == " " || c == "\t" || c == 8'h0D || c == "\n") return;
    if (letter(c)) begin
      open_run(stt_pkg::MIdent);
      foreach (lx_prefix[i]) lx_prefix[i] = '0;
      lx_prefix[0] = c;
      return;
    end
    if (numeral(c)) begin
      open_run(stt_pkg::MNumber);
      return;
    end
    if (c == "\"") begin
      open_run(stt_pkg::MString);
      return;
    end
    case (c)
      "(": k = stt_pkg::KLParen;
      ")": k = stt_pkg::KRParen;
      "{": k = stt_pkg::KLBrace;
      "}": k = stt_pkg::KRBrace;
      ";": k = stt_pkg::KSemi;
      ",": k = stt_pkg::KComma;
      ".": k = stt_pkg::KDot;
      "+": k = stt_pkg::KPlus;
      "-": k = stt_pkg::KMinus;
      "*": k = stt_pkg::KStar;
      "/": begin hold_op(stt_pkg::PSlash); return; end
      "=": begin hold_op(stt_pkg::PEq); return; end
      "!": begin hold_op(stt_pkg::PBang); return; end
      "<": begin hold_op(stt_pkg::PLt); return; end
      ">": begin hold_op(stt_pkg::PGt); return; end
      default: begin
        put(stt_pkg::KBadChar, lx_off, 16'd0, lx_line, lx_col, 8'd0);
        lx_halted = 1'b1;
        return;
      end
    endcase
    put(k, lx_off, 16'd1, lx_line, lx_col, 8'd0);
  endfunction

  function automatic logic [5:0] single_kind(logic [2:0] p);
    case (p)
      stt_pkg::PEq:   return stt_pkg::KAssign;
      stt_pkg::PBang: return stt_pkg::KBang;
      stt_pkg::PLt:   return stt_pkg::KLt;
      default:        return stt_pkg::KGt;
    endcase
  endfunction

  // tokens caused by one accepted item, appended to the expected list
  function void lex_item(logic [7:0] cin, logic eot);
    logic [7:0] c;
    logic [7:0] d;
    logic       e;
    logic       fall;
    item_tokens.delete();
    if (lx_halted) return;
    e = eot || cin == 8'd0;
    c = e ? 8'd0 : cin;
    fall = 1'b0;
    if (lx_mode == stt_pkg::MEnded) begin
      put(stt_pkg::KEnd, lx_off, 16'd0, lx_line, lx_col, 8'd0);
    end else begin
      case (lx_mode)
        stt_pkg::MString: begin
          if (e) begin
            put_run(stt_pkg::KUnterm, 16'd0, 8'd0);
            lx_halted = 1'b1;
          end else if (c == "\"") begin
            grow_run();
            put_run(stt_pkg::KString, lx_run_len, 8'd0);
            lx_mode = stt_pkg::MIdle;
          end else if (c == "\\") begin
            grow_run();
            lx_mode = stt_pkg::MEscape;
          end else begin
            grow_run();
            put_run(stt_pkg::KStrByte, 16'd0, c);
          end
        end
        stt_pkg::MEscape: begin
          if (e) begin
            put_run(stt_pkg::KUnterm, 16'd0, 8'd0);
            lx_halted = 1'b1;
          end else begin
            d = c == "n" ? 8'h0A : c == "t" ? 8'h09 : c == "r" ? 8'h0D : c;
            grow_run();
            put_run(stt_pkg::KStrByte, 16'd0, d);
            lx_mode = stt_pkg::MString;
          end
        end
        stt_pkg::MComment: begin
          if (e || c == "\n") begin
            lx_mode = stt_pkg::MIdle;
            fall = 1'b1;
          end
        end
        stt_pkg::MIdent: begin
          if (!e && (letter(c) || numeral(c))) begin
            if (lx_run_len < stt_pkg::KeywordChars) lx_prefix[lx_run_len] = c;
            grow_run();
          end else begin
            put_word();
            lx_mode = stt_pkg::MIdle;
            fall = 1'b1;
          end
        end
        stt_pkg::MNumber: begin
          if (lx_held == stt_pkg::PDot) begin
            lx_held = stt_pkg::PNone;
            if (!e && numeral(c)) begin
              grow_run();
              grow_run();
              lx_mode = stt_pkg::MFraction;
            end else begin
              put_run(stt_pkg::KNumber, lx_run_len, 8'd0);
              put(stt_pkg::KDot, lx_op_off, 16'd1, lx_op_line, lx_op_col, 8'd0);
              lx_mode = stt_pkg::MIdle;
              fall = 1'b1;
            end
          end else if (!e && numeral(c)) begin
            grow_run();
          end else if (!e && c == ".") begin
            hold_op(stt_pkg::PDot);
          end else begin
            put_run(stt_pkg::KNumber, lx_run_len, 8'd0);
            lx_mode = stt_pkg::MIdle;
            fall = 1'b1;
          end
        end
        stt_pkg::MFraction: begin
          if (!e && numeral(c)) begin
            grow_run();
          end else begin
            put_run(stt_pkg::KNumber, lx_run_len, 8'd0);
            lx_mode = stt_pkg::MIdle;
            fall = 1'b1;
          end
        end
        default: begin
          lx_mode = stt_pkg::MIdle;
          if (lx_held == stt_pkg::PSlash) begin
            lx_held = stt_pkg::PNone;
            if (!e && c == "/") begin
              lx_mode = stt_pkg::MComment;
            end else begin
              put(stt_pkg::KSlash, lx_op_off, 16'd1, lx_op_line, lx_op_col, 8'd0);
              fall = 1'b1;
            end
          end else if (lx_held >= stt_pkg::PEq && lx_held <= stt_pkg::PGt) begin
            if (!e && c == "=") begin
              put(single_kind(lx_held) + 6'd1, lx_op_off, 16'd2, lx_op_line, lx_op_col, 8'd0);
            end else begin
              put(single_kind(lx_held), lx_op_off, 16'd1, lx_op_line, lx_op_col, 8'd0);
              fall = 1'b1;
            end
            lx_held = stt_pkg::PNone;
          end else begin
            lx_held = stt_pkg::PNone;
            fall = 1'b1;
          end
        end
      endcase
      if (fall && !lx_halted) lex_idle(c, e);
      if (!e && !lx_halted) begin
        if (lx_off != stt_pkg::OffMax) lx_off++;
        if (c == "\n") begin
          if (lx_line != stt_pkg::PosMax) lx_line++;
          lx_col = 16'd1;
        end else if (lx_col != stt_pkg::PosMax) begin
          lx_col++;
        end
      end
    end
    if (item_tokens.size() > 0) item_tokens[$].last = 1'b1;
    foreach (item_tokens[i]) expected_tokens.push_back(item_tokens[i]);
  endfunction

  task automatic send_byte(logic [7:0] b, logic eot);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.end_of_text <= eot;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    lex_item(b, eot);
    items_sent++;
  endtask

  task automatic send_text();
    while (text_q.size() > 0) send_byte(text_q.pop_front(), 1'b0);
  endtask

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function void add_blank();
    case ($urandom_range(0, 3))
      0: text_q.push_back(" ");
      1: text_q.push_back("\t");
      2: text_q.push_back(8'h0D);
      default: text_q.push_back("\n");
    endcase
  endfunction

  function automatic logic [7:0] word_char(bit first);
    case ($urandom_range(0, first ? 2 : 3))
      0: return 8'("a" + $urandom_range(0, 25));
      1: return 8'("A" + $urandom_range(0, 25));
      2: return "_";
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  function void add_digits(int n);
    repeat (n) text_q.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  // one random, mostly well formed token
  function void add_token();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1: add_text(keywords[$urandom_range(0, 19)]);
      2: begin
        text_q.push_back(word_char(1));
        repeat ($urandom_range(0, 10)) text_q.push_back(word_char(0));
      end
      3: begin
        add_digits($urandom_range(1, 4));
        if ($urandom_range(0, 1)) begin
          text_q.push_back(".");
          add_digits($urandom_range(0, 3));
        end
      end
      4, 5: add_text(operators[$urandom_range(0, 18)]);
      6, 7: begin
        text_q.push_back("\"");
        repeat ($urandom_range(0, 5)) begin
          b = 8'($urandom_range(1, 255));
          if (b == "\"") b = "\\";
          text_q.push_back(b);
          if (b == "\\") begin
            case ($urandom_range(0, 5))
              0: text_q.push_back("n");
              1: text_q.push_back("t");
              2: text_q.push_back("r");
              3: text_q.push_back("\"");
              4: text_q.push_back("\\");
              default: text_q.push_back(8'($urandom_range(1, 255)));
            endcase
          end
        end
        text_q.push_back("\"");
      end
      8: begin
        add_text("//");
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom_range(1, 255));
          text_q.push_back(b == "\n" ? 8'h20 : b);
        end
        text_q.push_back("\n");
      end
      default: text_q.push_back(operators[$urandom_range(0, 18)][0]);
    endcase
  endfunction

  task automatic test_directed();
    idle_on = 1'b1;
    add_text("let checkbox checkboxes=3.25;x1!=y<=z>=(a)<b>c{}");
    add_text(",7.w/ q==!e+1-2*6 // note\n\"a\\n\\t\\r\\\"\\\\\\q\"");
    send_text();
  endtask

  task automatic test_random_source();
    int unsigned target;
    target = items_sent + 60;
    while (items_sent < target) begin
      idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: text_q.push_back(".");
          1: add_text("/");
          2: add_text("12.");
          default: text_q.push_back(word_char(0));
        endcase
      end else begin
        add_token();
      end
      if ($urandom_range(0, 3) != 0) add_blank();
      send_text();
    end
  endtask

  // every way out of the stream stops it for good, so one is picked per run
  task automatic test_termination();
    idle_on = 1'b1;
    case ($urandom_range(0, 3))
      0: begin
        add_text("done ");
        send_text();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      1: begin
        add_text("12.");
        send_text();
        send_byte(8'd0, 1'b0);
      end
      2: begin
        add_text("\"ab");
        if ($urandom_range(0, 1)) text_q.push_back("\\");
        send_text();
        send_byte(8'd0, $urandom_range(0, 1));
      end
      default: begin
        add_text("ok ");
        send_text();
        send_byte($urandom_range(0, 1) ? 8'h80 + 8'($urandom_range(0, 127)) : "#", 1'b0);
      end
    endcase
    repeat (3) send_byte(8'($urandom_range(0, 255)), 1'(($urandom_range(0, 1))));
  endtask

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls and the comparison
  always @(posedge clk_i or negedge rst_ni) begin
    lexed_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token kind %0d", out_ch.kind);
        failed = 1'b1;
      end else begin
        want = expected_tokens.pop_front();
        if (out_ch.kind !== want.tok.kind) begin
          $error("kind: expected %0d, got %0d", want.tok.kind, out_ch.kind);
          failed = 1'b1;
        end
        if (out_ch.start_offset !== want.tok.start_offset) begin
          $error("start_offset: expected %0d, got %0d", want.tok.start_offset,
                 out_ch.start_offset);
          failed = 1'b1;
        end
        if (out_ch.token_length !== want.tok.token_length) begin
          $error("token_length: expected %0d, got %0d", want.tok.token_length,
                 out_ch.token_length);
          failed = 1'b1;
        end
        if (out_ch.token_line !== want.tok.token_line) begin
          $error("token_line: expected %0d, got %0d", want.tok.token_line, out_ch.token_line);
          failed = 1'b1;
        end
        if (out_ch.token_col !== want.tok.token_col) begin
          $error("token_col: expected %0d, got %0d", want.tok.token_col, out_ch.token_col);
          failed = 1'b1;
        end
        if (out_ch.string_byte !== want.tok.string_byte) begin
          $error("string_byte: expected %0d, got %0d", want.tok.string_byte,
                 out_ch.string_byte);
          failed = 1'b1;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          failed = 1'b1;
        end
      end
      if (idle_on && $urandom_range(0, 1)) begin
        out_ch.ready <= 1'b0;
        stall_left <= $urandom_range(1, 15);
      end
    end else if (!out_ch.ready) begin
      if (stall_left <= 1) out_ch.ready <= 1'b1;
      stall_left <= stall_left - 1;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    idle_on = 1'b1;
    items_sent = 0;
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    in_ch.end_of_text = 1'b0;
    lexer_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_source();
    test_termination();
    in_ch.valid <= 1'b0;
    while (expected_tokens.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed && expected_tokens.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
